@@ sv/buddy_page_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Concurrent assertion forms used by the allocator controller.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define BPA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ sv/buddy_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator package
// Widths, sizes and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package buddy_pkg;

    localparam int PAGE_COUNT = 4096;
    localparam int MAX_ORDER  = 10;
    localparam int ORDERS     = MAX_ORDER + 1;
    localparam int PFN_W      = 12;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 13;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_BUDDY_RD,
        OP_MERGE,
        OP_SETNODE,
        OP_PSTART,
        OP_PWR1,
        OP_PWR2,
        OP_AREAD,
        OP_AREMOVE,
        OP_SPLIT,
        OP_AFIN
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic found;
        logic at_max;
        logic buddy_match;
        logic more_split;
        logic mode_free;
    } status_t;

endpackage

`default_nettype wire

@@ sv/buddy_datapath.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Page metadata and link memories, free list heads, counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_datapath
    import buddy_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               mode,
    input  wire logic [PFN_W-1:0]   pfn,
    input  wire logic [ORD_W-1:0]   order,
    output logic                    ok,
    output logic [PFN_W-1:0]        pfn_out,
    output logic [CNT_W-1:0]        free_pages,
    output logic [CNT_W-1:0]        managed_pages
);

    // Per-page memories: {free head flag, order}, next link, previous link.
    logic [ORD_W:0]     meta_mem [PAGE_COUNT];
    logic [PFN_W-1:0]   next_mem [PAGE_COUNT];
    logic [PFN_W-1:0]   prev_mem [PAGE_COUNT];

    logic [ORD_W:0]     meta_q;
    logic [PFN_W-1:0]   next_q;
    logic [PFN_W-1:0]   prev_q;

    logic               head_v_reg   [ORDERS];
    logic [PFN_W-1:0]   head_idx_reg [ORDERS];
    logic               head_v_next   [ORDERS];
    logic [PFN_W-1:0]   head_idx_next [ORDERS];

    logic [PFN_W-1:0]   clr_reg, clr_next;
    logic [PFN_W-1:0]   cur_reg, cur_next;
    logic [PFN_W-1:0]   node_reg, node_next;
    logic [PFN_W-1:0]   t_reg, t_next;
    logic [ORD_W-1:0]   k_reg, k_next;
    logic [ORD_W-1:0]   req_reg, req_next;
    logic               mode_reg, mode_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]   mgd_reg, mgd_next;
    logic               ok_reg, ok_next;
    logic [PFN_W-1:0]   pfo_reg, pfo_next;

    logic               rd_en;
    logic [PFN_W-1:0]   rd_addr;
    logic               meta_we, next_we, prev_we;
    logic [PFN_W-1:0]   meta_wa, next_wa, prev_wa;
    logic [ORD_W:0]     meta_wd;
    logic [PFN_W-1:0]   next_wd, prev_wd;

    logic               found;
    logic [ORD_W-1:0]   found_k;
    logic [ORD_W-1:0]   ord_sat;
    logic [PFN_W-1:0]   kbit;
    logic [PFN_W-1:0]   km1bit;
    logic [ORD_W-1:0]   km1;
    logic [PFN_W-1:0]   buddy;
    logic [PFN_W-1:0]   rm_node;
    logic               is_head;

    always_comb
    begin
        found   = 1'b0;
        found_k = '0;
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            if (head_v_reg[i] && (ORD_W'(i) >= order))
            begin
                found   = 1'b1;
                found_k = ORD_W'(i);
            end
        end
    end

    assign ord_sat = (order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order;
    assign kbit    = PFN_W'(1) << k_reg;
    assign km1     = k_reg - ORD_W'(1);
    assign km1bit  = PFN_W'(1) << km1;
    assign buddy   = cur_reg ^ kbit;
    assign rm_node = (cmd.op == OP_MERGE) ? buddy : cur_reg;
    assign is_head = head_v_reg[k_reg] && (head_idx_reg[k_reg] == rm_node);

    assign status.clr_done    = (clr_reg == PFN_W'(PAGE_COUNT - 1));
    assign status.found       = found;
    assign status.at_max      = (k_reg == ORD_W'(MAX_ORDER));
    assign status.buddy_match = meta_q[ORD_W] && (meta_q[ORD_W-1:0] == k_reg);
    assign status.more_split  = (k_reg > req_reg);
    assign status.mode_free   = mode_reg;

    always_comb
    begin
        clr_next  = clr_reg;
        cur_next  = cur_reg;
        node_next = node_reg;
        t_next    = t_reg;
        k_next    = k_reg;
        req_next  = req_reg;
        mode_next = mode_reg;
        free_next = free_reg;
        mgd_next  = mgd_reg;
        ok_next   = ok_reg;
        pfo_next  = pfo_reg;
        for (int i = 0; i < ORDERS; i++)
        begin
            head_v_next[i]   = head_v_reg[i];
            head_idx_next[i] = head_idx_reg[i];
        end
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        meta_we = 1'b0;
        meta_wa = rm_node;
        meta_wd = '0;
        next_we = 1'b0;
        next_wa = node_reg;
        next_wd = node_reg;
        prev_we = 1'b0;
        prev_wa = node_reg;
        prev_wd = node_reg;

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                clr_next = clr_reg + PFN_W'(1);
            end
            OP_LOAD:
            begin
                mode_next = mode;
                req_next  = order;
                pfo_next  = '0;
                if (mode)
                begin
                    ok_next   = 1'b1;
                    k_next    = ord_sat;
                    cur_next  = pfn & ~((PFN_W'(1) << ord_sat) - PFN_W'(1));
                    free_next = free_reg + (CNT_W'(1) << ord_sat);
                    mgd_next  = mgd_reg + (CNT_W'(1) << ord_sat);
                end
                else
                begin
                    ok_next  = 1'b0;
                    k_next   = found_k;
                    cur_next = head_idx_reg[found_k];
                end
            end
            OP_BUDDY_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = buddy;
            end
            OP_AREAD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
            end
            OP_MERGE, OP_AREMOVE:
            begin
                meta_we = 1'b1;
                if (next_q == rm_node)
                begin
                    if (is_head)
                        head_v_next[k_reg] = 1'b0;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_q;
                    next_wd = next_q;
                    prev_we = 1'b1;
                    prev_wa = next_q;
                    prev_wd = prev_q;
                    if (is_head)
                        head_idx_next[k_reg] = next_q;
                end
                if (cmd.op == OP_MERGE)
                begin
                    cur_next = cur_reg & ~kbit;
                    k_next   = k_reg + ORD_W'(1);
                end
            end
            OP_SETNODE:
            begin
                node_next = cur_reg;
            end
            OP_SPLIT:
            begin
                k_next    = km1;
                node_next = cur_reg + km1bit;
            end
            OP_PSTART:
            begin
                meta_we = 1'b1;
                meta_wa = node_reg;
                meta_wd = {1'b1, k_reg};
                rd_en   = 1'b1;
                rd_addr = head_idx_reg[k_reg];
            end
            OP_PWR1:
            begin
                t_next  = prev_q;
                next_we = 1'b1;
                prev_we = 1'b1;
                if (head_v_reg[k_reg])
                begin
                    next_wd = head_idx_reg[k_reg];
                    prev_wd = prev_q;
                end
            end
            OP_PWR2:
            begin
                if (head_v_reg[k_reg])
                begin
                    next_we = 1'b1;
                    next_wa = t_reg;
                    prev_we = 1'b1;
                    prev_wa = head_idx_reg[k_reg];
                end
                head_v_next[k_reg]   = 1'b1;
                head_idx_next[k_reg] = node_reg;
            end
            OP_AFIN:
            begin
                ok_next   = 1'b1;
                pfo_next  = cur_reg;
                free_next = free_reg - (CNT_W'(1) << req_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (rd_en)
        begin
            meta_q <= meta_mem[rd_addr];
            next_q <= next_mem[rd_addr];
            prev_q <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            mode_reg <= 1'b0;
            free_reg <= '0;
            mgd_reg  <= '0;
            ok_reg   <= 1'b0;
            pfo_reg  <= '0;
            for (int i = 0; i < ORDERS; i++)
                head_v_reg[i] <= 1'b0;
        end
        else
        begin
            clr_reg  <= clr_next;
            mode_reg <= mode_next;
            free_reg <= free_next;
            mgd_reg  <= mgd_next;
            ok_reg   <= ok_next;
            pfo_reg  <= pfo_next;
            for (int i = 0; i < ORDERS; i++)
                head_v_reg[i] <= head_v_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        node_reg <= node_next;
        t_reg    <= t_next;
        k_reg    <= k_next;
        req_reg  <= req_next;
        for (int i = 0; i < ORDERS; i++)
            head_idx_reg[i] <= head_idx_next[i];
    end

    assign ok            = ok_reg;
    assign pfn_out       = pfo_reg;
    assign free_pages    = free_reg;
    assign managed_pages = mgd_reg;

endmodule

`default_nettype wire

@@ sv/buddy_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the clearing pass, free merges, allocation splits and list pushes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_page_allocator_unit_macros.svh"

module buddy_ctrl
    import buddy_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    mode,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_FLOOP = 12'b000000000100,
        S_FCHK  = 12'b000000001000,
        S_PST   = 12'b000000010000,
        S_PWR1  = 12'b000000100000,
        S_PWR2  = 12'b000001000000,
        S_ARD   = 12'b000010000000,
        S_ARM   = 12'b000100000000,
        S_ASPL  = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (mode)
                        state_next = S_FLOOP;
                    else if (status.found)
                        state_next = S_ARD;
                    else
                        state_next = S_DONE;
                end
            end
            S_FLOOP:
            begin
                if (status.at_max)
                begin
                    cmd.op     = OP_SETNODE;
                    state_next = S_PST;
                end
                else
                begin
                    cmd.op     = OP_BUDDY_RD;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (status.buddy_match)
                begin
                    cmd.op     = OP_MERGE;
                    state_next = S_FLOOP;
                end
                else
                begin
                    cmd.op     = OP_SETNODE;
                    state_next = S_PST;
                end
            end
            S_PST:
            begin
                cmd.op     = OP_PSTART;
                state_next = S_PWR1;
            end
            S_PWR1:
            begin
                cmd.op     = OP_PWR1;
                state_next = S_PWR2;
            end
            S_PWR2:
            begin
                cmd.op     = OP_PWR2;
                state_next = status.mode_free ? S_DONE : S_ASPL;
            end
            S_ARD:
            begin
                cmd.op     = OP_AREAD;
                state_next = S_ARM;
            end
            S_ARM:
            begin
                cmd.op     = OP_AREMOVE;
                state_next = S_ASPL;
            end
            S_ASPL:
            begin
                if (status.more_split)
                begin
                    cmd.op     = OP_SPLIT;
                    state_next = S_PST;
                end
                else
                begin
                    cmd.op     = OP_AFIN;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `BPA_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_reg), "state is not one-hot")
    `BPA_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept did not raise busy")
    `BPA_ASSERT(a_done_single, clk, rst_n, done |=> !done, "result strobe longer than one cycle")
    `BPA_NEVER(a_done_idle, clk, rst_n, done && !busy, "result strobe while idle")

endmodule

`default_nettype wire

@@ sv/buddy_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator unit
// Binary buddy allocator over 4096 pages with block orders 0 to 10.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the page metadata memory,
// during which busy is high. A word is accepted when start is high and busy
// is low; the unit then stays busy until the result word is shown for exactly
// one cycle with done high, and the receiver cannot stall it. A free merges
// with its buddy one order per step while the buddy is a free block of the
// same order and order 10 is not reached, then pushes the block on its list.
// An allocation takes the smallest free block at or above the requested order,
// splits it one order per step and pushes each upper half; a failed one goes
// straight to the result word. Each page memory has a single read and write
// port, walked one order per step by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_unit
    import buddy_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [PFN_W-1:0]   pfn,
    input  wire logic [ORD_W-1:0]   order,
    output logic                    done,
    output logic                    ok,
    output logic [PFN_W-1:0]        pfn_out,
    output logic [CNT_W-1:0]        free_pages,
    output logic [CNT_W-1:0]        managed_pages
);

    // Commands flow from the controller to the datapath; status flows back.
    cmd_t    cmd;
    status_t status;

    buddy_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    buddy_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .pfn           (pfn),
        .order         (order),
        .ok            (ok),
        .pfn_out       (pfn_out),
        .free_pages    (free_pages),
        .managed_pages (managed_pages)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator unit testbench
// Drives free and allocate words into the unit and checks every result word
// against a page-level buddy model kept inside the bench. Frees are built only
// from held or never-managed blocks, so lists always stay consistent.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import buddy_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_WORDS  = 1550;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Ownership of each page as the stimulus side sees it.
    typedef enum logic [1:0] {PG_UNMANAGED, PG_HELD, PG_FREE} page_own_t;

    typedef struct {
        logic               ok;
        logic [PFN_W-1:0]   pfn;
        logic [CNT_W-1:0]   free_cnt;
        logic [CNT_W-1:0]   managed_cnt;
    } alloc_result_t;

    typedef struct {
        logic               mode;
        logic [PFN_W-1:0]   pfn;
        logic [ORD_W-1:0]   order;
        bit                 drain_first;
        alloc_result_t      want;
    } alloc_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               mode;
    logic [PFN_W-1:0]   pfn;
    logic [ORD_W-1:0]   order;
    logic               done;
    logic               ok;
    logic [PFN_W-1:0]   pfn_out;
    logic [CNT_W-1:0]   free_pages;
    logic [CNT_W-1:0]   managed_pages;

    buddy_page_allocator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .pfn           (pfn),
        .order         (order),
        .done          (done),
        .ok            (ok),
        .pfn_out       (pfn_out),
        .free_pages    (free_pages),
        .managed_pages (managed_pages)
    );

    // The unit's free-list state as the bench predicts it.
    bit             head_flag [PAGE_COUNT];
    int             blk_ord   [PAGE_COUNT];
    int             link_fwd  [PAGE_COUNT];
    int             link_back [PAGE_COUNT];
    bit             list_valid[ORDERS];
    int             list_top  [ORDERS];
    int             list_len  [ORDERS];
    int             pages_free;
    int             pages_managed;

    // Stimulus bookkeeping: page ownership and the blocks the bench holds.
    page_own_t      page_own  [PAGE_COUNT];
    int             held_pfn[$];
    int             held_ord[$];

    alloc_word_t    pending_words[$];
    alloc_result_t  due_results[$];

    bit             word_taken;
    int             burst_left;
    int             gap_left;
    int             idle_cycles;
    int             mismatches;

    always #5 clk = ~clk;

    task automatic list_insert(input int node, input int k);
        int h;
        int t;
        begin
            if (list_valid[k])
            begin
                h = list_top[k];
                t = link_back[h];
                link_fwd[node]  = h;
                link_back[node] = t;
                link_fwd[t]     = node;
                link_back[h]    = node;
            end
            else
            begin
                link_fwd[node]  = node;
                link_back[node] = node;
            end
            list_valid[k] = 1'b1;
            list_top[k]   = node;
            list_len[k]   = (list_len[k] + 1) & 16'h1fff;
        end
    endtask

    task automatic list_unlink(input int node, input int k);
        int n;
        int p;
        bit at_top;
        begin
            n = link_fwd[node];
            p = link_back[node];
            at_top = list_valid[k] && (list_top[k] == node);
            if (n == node)
            begin
                if (at_top)
                    list_valid[k] = 1'b0;
            end
            else
            begin
                link_fwd[p]  = n;
                link_back[n] = p;
                if (at_top)
                    list_top[k] = n;
            end
            list_len[k] = (list_len[k] - 1) & 16'h1fff;
        end
    endtask

    // Computes the result word of one command and advances the model state.
    task automatic predict_buddy(input logic m, input logic [PFN_W-1:0] p_in,
                                 input logic [ORD_W-1:0] o_in,
                                 output alloc_result_t r);
        int o;
        int k;
        int p;
        int mate;
        int top;
        int upper;
        begin
            r.ok  = 1'b0;
            r.pfn = '0;
            o = o_in;
            p = p_in;
            if (m == MODE_FREE)
            begin
                if (o > MAX_ORDER)
                    o = MAX_ORDER;
                p = p & ~((1 << o) - 1);
                if (p < PAGE_COUNT)
                begin
                    r.ok = 1'b1;
                    pages_managed = (pages_managed + (1 << o)) & 16'h1fff;
                    pages_free    = (pages_free + (1 << o)) & 16'h1fff;
                    while (o < MAX_ORDER)
                    begin
                        mate = p ^ (1 << o);
                        if (mate >= PAGE_COUNT || !head_flag[mate] || blk_ord[mate] != o)
                            break;
                        list_unlink(mate, o);
                        head_flag[mate] = 1'b0;
                        blk_ord[mate]   = 0;
                        p = p & ~(1 << o);
                        o++;
                    end
                    head_flag[p] = 1'b1;
                    blk_ord[p]   = o;
                    list_insert(p, o);
                end
            end
            else
            begin
                k = o;
                while (k < ORDERS && !list_valid[k])
                    k++;
                if (k < ORDERS)
                begin
                    top = list_top[k];
                    list_unlink(top, k);
                    head_flag[top] = 1'b0;
                    blk_ord[top]   = 0;
                    while (k > o)
                    begin
                        k--;
                        upper = top + (1 << k);
                        if (upper < PAGE_COUNT)
                        begin
                            head_flag[upper] = 1'b1;
                            blk_ord[upper]   = k;
                            list_insert(upper, k);
                        end
                    end
                    pages_free = (pages_free - (1 << o)) & 16'h1fff;
                    r.ok  = 1'b1;
                    r.pfn = top[PFN_W-1:0];
                end
            end
            r.free_cnt    = pages_free[CNT_W-1:0];
            r.managed_cnt = pages_managed[CNT_W-1:0];
        end
    endtask

    // Predicts the word, updates page ownership and queues it for the driver.
    task automatic queue_word(input logic m, input logic [PFN_W-1:0] p,
                              input logic [ORD_W-1:0] o, input bit drain);
        alloc_word_t w;
        int sz;
        int base;
        begin
            w.mode = m;
            w.pfn = p;
            w.order = o;
            w.drain_first = drain;
            predict_buddy(m, p, o, w.want);
            if (m == MODE_FREE)
            begin
                sz = 1 << ((o > MAX_ORDER) ? MAX_ORDER : o);
                base = p & ~(sz - 1);
                for (int i = base; i < base + sz; i++)
                    page_own[i] = PG_FREE;
            end
            else if (w.want.ok)
            begin
                sz = 1 << o;
                for (int i = 0; i < sz; i++)
                    page_own[w.want.pfn + i] = PG_HELD;
                held_pfn.push_back(w.want.pfn);
                held_ord.push_back(o);
            end
            pending_words.push_back(w);
        end
    endtask

    // Hands a never-managed block to the allocator; returns 0 if none was found.
    task automatic seed_block(input int o, input bit drain, output bit done_seed);
        int base;
        int sz;
        bit clean;
        begin
            done_seed = 1'b0;
            sz = 1 << o;
            for (int tries = 0; tries < 8 && !done_seed; tries++)
            begin
                base = $urandom_range(0, PAGE_COUNT - 1) & ~(sz - 1);
                clean = 1'b1;
                for (int i = base; i < base + sz; i++)
                    if (page_own[i] != PG_UNMANAGED)
                        clean = 1'b0;
                if (clean)
                begin
                    // Low bits below the block size are dropped by the unit.
                    queue_word(MODE_FREE, PFN_W'(base | ($urandom & (sz - 1))),
                               ORD_W'((o == MAX_ORDER) ? $urandom_range(MAX_ORDER, 15) : o),
                               drain);
                    done_seed = 1'b1;
                end
            end
        end
    endtask

    // Returns one held block, chosen at random, with random low pfn bits.
    task automatic release_held(input bit drain);
        int idx;
        int o;
        begin
            idx = $urandom_range(0, held_pfn.size() - 1);
            o = held_ord[idx];
            queue_word(MODE_FREE, PFN_W'(held_pfn[idx] | ($urandom & ((1 << o) - 1))),
                       ORD_W'((o == MAX_ORDER) ? $urandom_range(MAX_ORDER, 15) : o),
                       drain);
            held_pfn.delete(idx);
            held_ord.delete(idx);
        end
    endtask

    // Driver: presents words at the falling edge, in bursts with gaps.
    always @(negedge clk)
    begin
        bit nxt_start;
        nxt_start = 1'b0;
        if (rst_n)
        begin
            if (word_taken)
                void'(pending_words.pop_front());
            if (pending_words.size() > 0)
            begin
                if (pending_words[0].drain_first && due_results.size() > 0)
                    nxt_start = 1'b0;
                else if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else
                begin
                    nxt_start = 1'b1;
                    if (word_taken || !start)
                    begin
                        if (burst_left > 0)
                            burst_left <= burst_left - 1;
                        else
                        begin
                            burst_left <= $urandom_range(0, 12);
                            gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                                        $urandom_range(1, 40);
                        end
                    end
                end
            end
            if (pending_words.size() > 0)
            begin
                mode  <= pending_words[0].mode;
                pfn   <= pending_words[0].pfn;
                order <= pending_words[0].order;
            end
        end
        start <= nxt_start;
    end

    // Monitor: records accepted words and checks result words at the rising edge.
    always @(posedge clk)
    begin
        alloc_result_t w;
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                due_results.push_back(pending_words[0].want);
                took = 1'b1;
            end
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word ok=%0d pfn_out=%0d", ok, pfn_out);
                end
                else
                begin
                    w = due_results.pop_front();
                    if (ok !== w.ok || pfn_out !== w.pfn || free_pages !== w.free_cnt ||
                        managed_pages !== w.managed_cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: want ok=%0d pfn=%0d free=%0d managed=%0d, ",
                                   w.ok, w.pfn, w.free_cnt, w.managed_cnt);
                            $display("got ok=%0d pfn=%0d free=%0d managed=%0d",
                                     ok, pfn_out, free_pages, managed_pages);
                        end
                    end
                end
            end
        end
        word_taken <= took;
    end

    // Watchdog on cycles in which no word moves in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("buddy_page_allocator_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        bit seeded;
        int pick;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ALLOC;
        pfn = '0;
        order = '0;
        word_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        idle_cycles = 0;
        mismatches = 0;
        pages_free = 0;
        pages_managed = 0;
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            head_flag[i] = 1'b0;
            blk_ord[i]   = 0;
            link_fwd[i]  = 0;
            link_back[i] = 0;
            page_own[i]  = PG_UNMANAGED;
        end
        for (int k = 0; k < ORDERS; k++)
        begin
            list_valid[k] = 1'b0;
            list_top[k]   = 0;
            list_len[k]   = 0;
        end

        // Directed part: empty zone, oversize orders, unaligned frees and merges.
        queue_word(MODE_ALLOC, 12'hfff, 4'd0, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd15, 1'b0);
        queue_word(MODE_FREE, 12'd0, 4'd0, 1'b0);
        queue_word(MODE_FREE, 12'd1, 4'd0, 1'b0);
        queue_word(MODE_FREE, 12'd3, 4'd1, 1'b0);
        queue_word(MODE_FREE, 12'hfff, 4'd15, 1'b0);
        queue_word(MODE_ALLOC, 12'hfff, 4'd11, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd0, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd10, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd10, 1'b0);
        queue_word(MODE_FREE, 12'd7, 4'd2, 1'b1);
        queue_word(MODE_FREE, 12'd2048, 4'd10, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd0, 1'b0);
        queue_word(MODE_ALLOC, 12'h000, 4'd3, 1'b0);
        // Hand back everything held so far, which merges back up.
        while (held_pfn.size() > 0)
            release_held(1'b0);

        // Random part: mostly legal frees and allocations, some failing requests.
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            seeded = 1'b0;
            if (pick < 15)
                seed_block($urandom_range(0, MAX_ORDER), (n % 300) == 299, seeded);
            else if (pick < 55 && held_pfn.size() > 0)
            begin
                release_held((n % 300) == 299);
                seeded = 1'b1;
            end
            if (!seeded)
                queue_word(MODE_ALLOC, PFN_W'($urandom),
                           ORD_W'(($urandom_range(0, 19) == 0) ? $urandom_range(11, 15) :
                                  $urandom_range(0, MAX_ORDER)),
                           (n % 300) == 299);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && due_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("buddy_page_allocator_unit regression: pass");
        else
            $display("buddy_page_allocator_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/buddy_pkg.sv
sv/buddy_datapath.sv
sv/buddy_ctrl.sv
sv/buddy_page_allocator_unit.sv
verif/tb.sv
